### src/crx_pkg.sv
`default_nettype none

package crx_pkg;

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  localparam logic [1:0] CLASS_LOWER = 2'd0;
  localparam logic [1:0] CLASS_UPPER = 2'd1;
  localparam logic [1:0] CLASS_DIGIT = 2'd2;
  localparam logic [1:0] CLASS_NONE  = 2'd3;

  // One run of output characters from lo up to hi; a literal has lo equal to hi.
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       last;
  } crx_cmd_t;

  function automatic logic [1:0] char_class(input logic [7:0] c);
    logic [1:0] cls;
    cls = CLASS_NONE;
    if (c inside {[8'h61:8'h7A]}) begin
      cls = CLASS_LOWER;
    end else if (c inside {[8'h41:8'h5A]}) begin
      cls = CLASS_UPPER;
    end else if (c inside {[8'h30:8'h39]}) begin
      cls = CLASS_DIGIT;
    end
    return cls;
  endfunction

  function automatic logic is_range(input logic [7:0] x, input logic [7:0] mid,
                                    input logic [7:0] y);
    logic [1:0] cx;
    cx = char_class(x);
    return (mid == DASH_CHAR) && (cx != CLASS_NONE) && (cx == char_class(y)) && (x <= y);
  endfunction

endpackage

`default_nettype wire

### src/crx_fifo.sv
`default_nettype none

module crx_fifo
  import crx_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire crx_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output crx_cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  crx_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### src/crx_front.sv
`default_nettype none

module crx_front
  import crx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       fifo_full,
  output logic            push,
  output crx_cmd_t        push_cmd
);

  logic [7:0] p0_r, p0_nxt;
  logic [7:0] p1_r, p1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       flush_r, flush_nxt;
  logic       accept;

  assign in_tready = !flush_r && !fifo_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    cnt_nxt   = cnt_r;
    flush_nxt = flush_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (accept) begin
      if (cnt_r == 2'd2) begin
        push = 1'b1;
        if (is_range(p0_r, p1_r, in_tdata)) begin
          push_cmd = '{lo: p0_r, hi: in_tdata, last: in_tlast};
          cnt_nxt  = 2'd0;
        end else begin
          push_cmd = '{lo: p0_r, hi: p0_r, last: 1'b0};
          p0_nxt   = p1_r;
          p1_nxt   = in_tdata;
        end
      end else if (cnt_r == 2'd1) begin
        p1_nxt  = in_tdata;
        cnt_nxt = 2'd2;
      end else begin
        p0_nxt  = in_tdata;
        cnt_nxt = 2'd1;
      end
      if (in_tlast && (cnt_nxt != 2'd0)) begin
        flush_nxt = 1'b1;
      end
    end else if (flush_r && !fifo_full) begin
      push     = 1'b1;
      push_cmd = '{lo: p0_r, hi: p0_r, last: (cnt_r == 2'd1)};
      p0_nxt   = p1_r;
      cnt_nxt  = cnt_r - 2'd1;
      if (cnt_r == 2'd1) begin
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
  end

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3) && (!flush_r || (cnt_r != 2'd0)))
    else $error("window count out of range");

endmodule

`default_nettype wire

### src/crx_back.sv
`default_nettype none

module crx_back
  import crx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fifo_not_empty,
  input  wire crx_cmd_t head_cmd,
  output logic          pop,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  logic [7:0] cur_r;
  logic [7:0] hi_r;
  logic       end_r;
  logic       busy_r;
  logic       fire;
  logic       run_done;

  assign fire       = busy_r && out_tready;
  assign run_done   = (cur_r == hi_r);
  assign pop        = fifo_not_empty && (!busy_r || (fire && run_done));
  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r;
  assign out_tlast  = end_r && run_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
    end else if (fire && run_done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd.lo;
      hi_r  <= head_cmd.hi;
      end_r <= head_cmd.last;
    end else if (fire) begin
      cur_r <= cur_r + 8'd1;
    end
  end

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r <= hi_r))
    else $error("run counter passed its upper bound");

endmodule

`default_nettype wire

### src/char_range_expander.sv
// Character range expander.
// Input: in_tvalid/in_tready carry one character a word in in_tdata, with
// in_tlast on the final character of a string. Output: out_tvalid/out_tready
// carry one character a word in out_tdata, with out_tlast on the final
// character of the expanded string.
// A front end keeps a window of up to two characters and turns each word
// into run commands; a small queue of QUEUE_DEPTH commands feeds a back end
// that emits one character per cycle while out_tready is high, counting from
// the start to the end of each run.
// Throughput: one input word per cycle while the queue has room. An expanded
// range occupies the back end until all its characters are emitted, so
// input stalls once the queue fills. A final character needing a flush
// holds in_tready low while the leftover window is queued.
// Reset empties the window and the queue and drops any partial output.
// When out_tready is low the current word holds and the front end keeps
// accepting until the queue is full.
`default_nettype none

module char_range_expander
  import crx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // in_char
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_char
  output logic            out_tlast
);

  logic     push;
  crx_cmd_t push_cmd;
  logic     fifo_full;
  logic     pop;
  logic     fifo_not_empty;
  crx_cmd_t head_cmd;

  crx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  crx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_not_empty),
    .head_cmd  (head_cmd)
  );

  crx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_not_empty (fifo_not_empty),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule

`default_nettype wire
